>>> src/fsg_pkg.sv
// Shared types and codes for the falling-sand grid block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package fsg_pkg;

  typedef enum logic [1:0] {
    CELL_EMPTY = 2'd0,
    CELL_SAND  = 2'd1,
    CELL_WATER = 2'd2,
    CELL_ROCK  = 2'd3
  } cell_t;

  localparam logic [1:0] ACT_PLACE = 2'd0;
  localparam logic [1:0] ACT_STEP  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } sweep_stat_t;

endpackage

`default_nettype wire

>>> src/fsg_grid_mem.sv
// Cell store: one write port, one read port with registered read data.
// Depends on fsg_pkg for the cell type.
`timescale 1ns / 1ps
`default_nettype none

module fsg_grid_mem #(
  parameter int AW = 12
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire fsg_pkg::cell_t   wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output fsg_pkg::cell_t        rd_data
);
  import fsg_pkg::*;

  localparam int DEPTH = 1 << AW;

  cell_t mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> src/fsg_sweep.sv
// Update sweep: walks the rows bottom-up with a three-column window over a row
// and the row below, fetching one column and retiring one column per step.
// Depends on fsg_pkg for the cell type and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module fsg_sweep #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64,
  parameter int AW          = 12
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output fsg_pkg::sweep_stat_t      stat,
  output logic                      rd_en,
  output logic [AW-1:0]             rd_addr,
  input  wire fsg_pkg::cell_t       rd_data,
  output logic                      wr_en,
  output logic [AW-1:0]             wr_addr,
  output fsg_pkg::cell_t            wr_data
);
  import fsg_pkg::*;

  localparam int CW = $clog2(GRID_WIDTH);
  localparam int RW = $clog2(GRID_HEIGHT);
  localparam int KW = $clog2(GRID_WIDTH + 3);

  localparam logic [KW-1:0] K_TWO   = KW'(2);
  localparam logic [KW-1:0] K_THREE = KW'(3);
  localparam logic [KW-1:0] K_W     = KW'(GRID_WIDTH);
  localparam logic [KW-1:0] K_WP1   = KW'(GRID_WIDTH + 1);
  localparam logic [KW-1:0] K_LAST  = KW'(GRID_WIDTH + 2);
  localparam logic [RW-1:0] ROW_FIRST = RW'(GRID_HEIGHT - 2);
  localparam logic [RW-1:0] ROW_ONE   = RW'(1);

  // k is the column being fetched; column k-2 is processed and k-3 retired
  logic          active;
  logic          done;
  logic          ph;
  logic [KW-1:0] k;
  logic [RW-1:0] r;

  cell_t ntop, l_top, l_bot, c_top, c_bot, pend_bot;
  cell_t nbot;
  cell_t lt_n, lb_n, ct_n, cb_n, nt_n, nb_n;
  logic  proc, left_ok, right_ok;
  logic [RW-1:0] r_below;
  logic [CW-1:0] col_rd, col_wr;

  assign nbot     = rd_data;
  assign proc     = (k >= K_TWO) && (k <= K_WP1);
  assign left_ok  = (k >= K_THREE);
  assign right_ok = (k <= K_W);
  assign r_below  = r + ROW_ONE;
  assign col_rd   = k[CW-1:0];
  assign col_wr   = CW'(k - K_THREE);

  always_comb begin
    lt_n = l_top;
    lb_n = l_bot;
    ct_n = c_top;
    cb_n = c_bot;
    nt_n = ntop;
    nb_n = nbot;
    if (proc) begin
      case (c_top)
        CELL_SAND: begin
          if (c_bot == CELL_EMPTY) begin
            ct_n = CELL_EMPTY;
            cb_n = CELL_SAND;
          end else if (left_ok && l_bot == CELL_EMPTY) begin
            ct_n = CELL_EMPTY;
            lb_n = CELL_SAND;
          end else if (right_ok && nbot == CELL_EMPTY) begin
            ct_n = CELL_EMPTY;
            nb_n = CELL_SAND;
          end
        end
        CELL_WATER: begin
          if (c_bot == CELL_EMPTY) begin
            ct_n = CELL_EMPTY;
            cb_n = CELL_WATER;
          end else if (left_ok && l_top == CELL_EMPTY) begin
            ct_n = CELL_EMPTY;
            lt_n = CELL_WATER;
          end else if (right_ok && ntop == CELL_EMPTY) begin
            // lands in the next column, which is processed next
            ct_n = CELL_EMPTY;
            nt_n = CELL_WATER;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rd_en   = active && (k < K_W);
    rd_addr = {(ph ? r_below : r), col_rd};
    wr_en   = active && left_ok;
    wr_addr = {(ph ? r_below : r), col_wr};
    wr_data = ph ? pend_bot : lt_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      ph     <= 1'b0;
      k      <= '0;
      r      <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        ph     <= 1'b0;
        k      <= '0;
        r      <= ROW_FIRST;
      end else if (active) begin
        ph <= ~ph;
        if (ph) begin
          if (k == K_LAST) begin
            k <= '0;
            if (r == '0) begin
              active <= 1'b0;
              done   <= 1'b1;
            end else begin
              r <= r - ROW_ONE;
            end
          end else begin
            k <= k + KW'(1);
          end
        end
      end
    end
  end

  // window: shift on the first phase, capture the fetched top cell on the second
  always_ff @(posedge clk) begin
    if (active) begin
      if (!ph) begin
        l_top    <= ct_n;
        l_bot    <= cb_n;
        c_top    <= nt_n;
        c_bot    <= nb_n;
        pend_bot <= lb_n;
      end else if (k < K_W) begin
        ntop <= rd_data;
      end
    end
  end

  assign stat.busy = active;
  assign stat.done = done;

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("sweep reads the entry it writes");

  a_done_after_active: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(active))
    else $error("sweep done without a running sweep");

  a_ph_idle: assert property (@(posedge clk) disable iff (rst)
    (!active && !start) |=> (!active || $past(start)))
    else $error("sweep started without a start pulse");

endmodule

`default_nettype wire

>>> src/falling_sand_grid_step.sv
//  channel | signals                          | direction | accepted when
//  req     | action, col, row, material       | in        | req_valid && !req_stall
//  rsp     | cell_value, in_range             | out       | rsp_valid && !rsp_stall
//
// Step is paced by the single read port and single write port, since each cell
// needs two fetches and two write-backs. After reset a clearing pass empties
// every entry of the store; req_stall stays high until it ends.
// A new request is taken while a finished response is still stalled.
// Top level of the falling-sand grid; depends on fsg_pkg, fsg_grid_mem, fsg_sweep.
`timescale 1ns / 1ps
`default_nettype none

module falling_sand_grid_step #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [1:0]  action,
  input  wire logic [5:0]  col,
  input  wire logic [5:0]  row,
  input  wire logic [1:0]  material,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic [1:0]       cell_value,
  output logic             in_range
);
  import fsg_pkg::*;

  localparam int CW = $clog2(GRID_WIDTH);
  localparam int RW = $clog2(GRID_HEIGHT);
  localparam int AW = CW + RW;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_PLACE  = 7'b0000100,
    S_READ   = 7'b0001000,
    S_READW  = 7'b0010000,
    S_SWEEP  = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [AW-1:0] clr_addr;
  logic          req_acc;
  logic          in_grid;
  logic          inside_q;
  logic [5:0]    col_q, row_q;
  logic [1:0]    mat_q;
  logic [AW-1:0] item_addr;
  cell_t         res_value;
  logic          res_flag;
  logic          rsp_load;

  logic          mem_wr_en, mem_rd_en;
  logic [AW-1:0] mem_wr_addr, mem_rd_addr;
  cell_t         mem_wr_data, mem_rd_data;

  logic          sw_start;
  sweep_stat_t   sw_stat;
  logic          sw_rd_en, sw_wr_en;
  logic [AW-1:0] sw_rd_addr, sw_wr_addr;
  cell_t         sw_wr_data;

  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign in_grid   = (int'(col) < GRID_WIDTH) && (int'(row) < GRID_HEIGHT);
  assign sw_start  = req_acc && (action == ACT_STEP);
  assign item_addr = {RW'(row_q), CW'(col_q)};
  assign rsp_load  = (state == S_FINISH) && (!rsp_valid || !rsp_stall);

  fsg_grid_mem #(.AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  fsg_sweep #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT),
    .AW          (AW)
  ) u_sweep (
    .clk     (clk),
    .rst     (rst),
    .start   (sw_start),
    .stat    (sw_stat),
    .rd_en   (sw_rd_en),
    .rd_addr (sw_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (sw_wr_en),
    .wr_addr (sw_wr_addr),
    .wr_data (sw_wr_data)
  );

  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = item_addr;
    mem_wr_data = cell_t'(mat_q);
    mem_rd_en   = 1'b0;
    mem_rd_addr = item_addr;
    case (state)
      S_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_addr;
        mem_wr_data = CELL_EMPTY;
      end
      S_PLACE: begin
        mem_wr_en = inside_q;
      end
      S_READ: begin
        mem_rd_en = inside_q;
      end
      S_SWEEP: begin
        mem_wr_en   = sw_wr_en;
        mem_wr_addr = sw_wr_addr;
        mem_wr_data = sw_wr_data;
        mem_rd_en   = sw_rd_en;
        mem_rd_addr = sw_rd_addr;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == '1) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_acc) begin
          case (action)
            ACT_PLACE: state_next = S_PLACE;
            ACT_STEP:  state_next = S_SWEEP;
            ACT_READ:  state_next = S_READ;
            default:   state_next = S_FINISH;
          endcase
        end
      end
      S_PLACE: state_next = S_FINISH;
      S_READ:  state_next = S_READW;
      S_READW: state_next = S_FINISH;
      S_SWEEP: begin
        if (sw_stat.done) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (rsp_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // request hold and response staging
  always_ff @(posedge clk) begin
    if (req_acc) begin
      col_q     <= col;
      row_q     <= row;
      mat_q     <= material;
      inside_q  <= in_grid;
      res_value <= CELL_EMPTY;
      res_flag  <= 1'b0;
    end
    case (state)
      S_PLACE: res_flag <= inside_q;
      S_READW: begin
        res_value <= inside_q ? mem_rd_data : CELL_EMPTY;
        res_flag  <= inside_q;
      end
      S_SWEEP: begin
        if (sw_stat.done) res_flag <= 1'b1;
      end
      default: begin
      end
    endcase
    if (rsp_load) begin
      cell_value <= res_value;
      in_range   <= res_flag;
    end
  end

  a_sweep_in_state: assert property (@(posedge clk) disable iff (rst)
    (sw_stat.busy || sw_stat.done) |-> (state == S_SWEEP))
    else $error("sweep running outside the sweep state");

  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_FINISH))
    else $error("response raised without a finished request");

  a_place_in_grid: assert property (@(posedge clk) disable iff (rst)
    ((state == S_PLACE) && mem_wr_en) |-> inside_q)
    else $error("place wrote outside the grid");

endmodule

`default_nettype wire
